FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file rar_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/core/rar_pkg.sv
package rar_pkg;

   // field widths
   localparam int NUM_W     = 16;
   localparam int DEN_W     = 15;
   localparam int SUM_NUM_W = 32;
   localparam int SUM_DEN_W = 30;
   // magnitude of the cross sum, also the width of the gcd and quotients
   localparam int MAG_W     = 31;

   // packed bus widths, rounded up to whole bytes
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 64;

   // request field positions
   localparam int A_NUM_LSB = 0;
   localparam int A_DEN_LSB = A_NUM_LSB + NUM_W;
   localparam int B_NUM_LSB = A_DEN_LSB + DEN_W;
   localparam int B_DEN_LSB = B_NUM_LSB + NUM_W;
   localparam int REQ_USED_W = B_DEN_LSB + DEN_W;

   // response field positions
   localparam int SUM_NUM_LSB = 0;
   localparam int SUM_DEN_LSB = SUM_NUM_LSB + SUM_NUM_W;
   localparam int RSP_USED_W  = SUM_DEN_LSB + SUM_DEN_W;

   // division steps, one quotient bit each
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

FILE: rtl/core/rational_add_reduce_core.sv
// Channel | Dir | Contents (tdata, lowest bits first)
// req_*   | in  | a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero[63:62]
// rsp_*   | out | sum_num[31:0], sum_den[61:32], zero[63:62]
//
// One item at a time: req_tready is high only while the sequencer is idle.
// Every item passes the multiply states MUL0-MUL2 and the sign state; a zero sum then goes
// straight to the load. Otherwise the common-factor shifts, the binary gcd loop (one shift or
// subtract a cycle), 31 division steps and the load follow; a zero den skips shifts and gcd.
// A finished result waits in the output register while a new item may be taken; only the
// final load stalls on rsp_tready. Synchronous reset clears the sequencer and rsp_tvalid.
module rational_add_reduce_core
   import rar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // a_num, a_den, b_num, b_den, pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // sum_num, sum_den, pad
);

   typedef logic [3:0] state_type;

   localparam state_type ST_IDLE = 4'd0;
   localparam state_type ST_MUL0 = 4'd1;
   localparam state_type ST_MUL1 = 4'd2;
   localparam state_type ST_MUL2 = 4'd3;
   localparam state_type ST_SIGN = 4'd4;
   localparam state_type ST_TWOS = 4'd5;
   localparam state_type ST_GCD  = 4'd6;
   localparam state_type ST_DIV  = 4'd7;
   localparam state_type ST_OUT  = 4'd8;

   state_type state_ff, state_in;

   // captured operands
   logic signed [NUM_W-1:0] a_num_ff, a_num_in, b_num_ff, b_num_in;
   logic [DEN_W-1:0]        a_den_ff, a_den_in, b_den_ff, b_den_in;

   // shared multiplier
   logic signed [NUM_W-1:0]     mul_a, mul_b;
   logic signed [SUM_NUM_W-1:0] mul_p;

   logic signed [SUM_NUM_W-1:0] acc_ff, acc_in;
   logic [SUM_DEN_W-1:0]        den_ff, den_in;
   logic                        neg_ff, neg_in;
   logic [SUM_NUM_W-1:0]        acc_abs;

   // gcd working values
   logic [MAG_W-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [CNT_W-1:0] k_ff, k_in;

   // division: quotient registers start as dividends
   logic [MAG_W-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic [MAG_W-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W:0]   rn_sh, rd_sh, rn_sub, rd_sub;
   logic             rn_ge, rd_ge;

   // output register
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [SUM_NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [SUM_DEN_W-1:0] rsp_den_ff, rsp_den_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, rsp_den_ff, rsp_num_ff};

   // operand select for the multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL0: begin
            mul_a = a_num_ff;
            mul_b = signed'({1'b0, b_den_ff});
         end
         ST_MUL1: begin
            mul_a = b_num_ff;
            mul_b = signed'({1'b0, a_den_ff});
         end
         default: begin
            mul_a = signed'({1'b0, a_den_ff});
            mul_b = signed'({1'b0, b_den_ff});
         end
      endcase
      mul_p = SUM_NUM_W'(mul_a) * SUM_NUM_W'(mul_b);
   end

   assign acc_abs = acc_ff[SUM_NUM_W-1] ? (SUM_NUM_W'(0) - acc_ff) : acc_ff;

   // one restoring division step on both dividends against the same gcd
   always_comb begin
      rn_sh  = {rn_ff, qn_ff[MAG_W-1]};
      rd_sh  = {rd_ff, qd_ff[MAG_W-1]};
      rn_sub = rn_sh - {1'b0, g_ff};
      rd_sub = rd_sh - {1'b0, g_ff};
      rn_ge  = (rn_sh >= {1'b0, g_ff});
      rd_ge  = (rd_sh >= {1'b0, g_ff});
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      a_num_in      = a_num_ff;
      a_den_in      = a_den_ff;
      b_num_in      = b_num_ff;
      b_den_in      = b_den_ff;
      acc_in        = acc_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      g_in          = g_ff;
      k_in          = k_ff;
      qn_in         = qn_ff;
      qd_in         = qd_ff;
      rn_in         = rn_ff;
      rd_in         = rd_ff;
      cnt_in        = cnt_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_tvalid_in = rsp_tvalid_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_num_in = req_tdata[A_NUM_LSB +: NUM_W];
               a_den_in = req_tdata[A_DEN_LSB +: DEN_W];
               b_num_in = req_tdata[B_NUM_LSB +: NUM_W];
               b_den_in = req_tdata[B_DEN_LSB +: DEN_W];
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            acc_in   = mul_p;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = acc_ff + mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            den_in   = mul_p[SUM_DEN_W-1:0];
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            if (acc_ff == '0) begin
               // zero sum comes out as 0/1
               neg_in   = 1'b0;
               qn_in    = '0;
               qd_in    = MAG_W'(1);
               state_in = ST_OUT;
            end else begin
               neg_in = acc_ff[SUM_NUM_W-1];
               qn_in  = acc_abs[MAG_W-1:0];
               qd_in  = {1'b0, den_ff};
               x_in   = acc_abs[MAG_W-1:0];
               y_in   = {1'b0, den_ff};
               k_in   = '0;
               rn_in  = '0;
               rd_in  = '0;
               cnt_in = CNT_W'(DIV_STEPS - 1);
               if (den_ff == '0) begin
                  // gcd with zero is the magnitude itself
                  g_in     = acc_abs[MAG_W-1:0];
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_TWOS;
               end
            end
         end
         ST_TWOS: begin
            // strip common factors of two
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CNT_W'(1);
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            priority if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff == y_ff) begin
               g_in     = x_ff << k_ff;
               state_in = ST_DIV;
            end else if (x_ff > y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         ST_DIV: begin
            rn_in  = rn_ge ? rn_sub[MAG_W-1:0] : rn_sh[MAG_W-1:0];
            rd_in  = rd_ge ? rd_sub[MAG_W-1:0] : rd_sh[MAG_W-1:0];
            qn_in  = {qn_ff[MAG_W-2:0], rn_ge};
            qd_in  = {qd_ff[MAG_W-2:0], rd_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_num_in    = neg_ff ? (SUM_NUM_W'(0) - {1'b0, qn_ff}) : {1'b0, qn_ff};
               rsp_den_in    = qd_ff[SUM_DEN_W-1:0];
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_num_ff   <= a_num_in;
      a_den_ff   <= a_den_in;
      b_num_ff   <= b_num_in;
      b_den_ff   <= b_den_in;
      acc_ff     <= acc_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      cnt_ff     <= cnt_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

endmodule

FILE: rtl/core/rar_checker.sv
`include "assert_macros.svh"

module rar_checker
   import rar_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_fire;
   logic rsp_stall;
   logic rsp_zero_num;
   logic rsp_den_one;

   assign req_fire     = req_tvalid && req_tready;
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_zero_num = (rsp_tdata[SUM_NUM_LSB +: SUM_NUM_W] == '0);
   assign rsp_den_one  = (rsp_tdata[SUM_DEN_LSB +: SUM_DEN_W] == SUM_DEN_W'(1));

   // reset empties the output register
   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)

   // a stalled result holds its data
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // the sequencer is busy once an item is taken
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)

   // a zero numerator always comes with a unit denominator
   `ASSERT_IMPLIES(a_zero_is_0_over_1, clock, reset, rsp_tvalid && rsp_zero_num, rsp_den_one)

endmodule

bind rational_add_reduce_core rar_checker u_rar_checker (.*);

FILE: test/rational_sum_checker.sv
// Watches both channels of rational_add_reduce_core, predicts the reduced sum
// for every accepted item and compares each result against the oldest prediction.
module rational_sum_checker
   import rar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // a_num, a_den, b_num, b_den, pad
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // sum_num, sum_den, pad
   output int                     fail_count,
   output int                     pending_sums
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SUM_NUM_W-1:0] sum_num;
      logic        [SUM_DEN_W-1:0] sum_den;
   } sum_type;

   sum_type expected_sums[$];

   // a/b + c/d over the product denominator, divided through by the gcd of
   // the magnitudes; a zero denominator leaves the gcd equal to the numerator magnitude
   function automatic sum_type reduced_sum(logic [REQ_TDATA_W-1:0] item);
      longint  an, ad, bn, bd, num, den, mag, x, y, rem;
      sum_type res;
      an  = longint'(signed'(item[A_NUM_LSB +: NUM_W]));
      ad  = longint'(item[A_DEN_LSB +: DEN_W]);
      bn  = longint'(signed'(item[B_NUM_LSB +: NUM_W]));
      bd  = longint'(item[B_DEN_LSB +: DEN_W]);
      num = an * bd + bn * ad;
      den = ad * bd;
      if (num == 0) begin
         res.sum_num = '0;
         res.sum_den = SUM_DEN_W'(1);
         return res;
      end
      mag = (num < 0) ? -num : num;
      x   = mag;
      y   = den;
      while (y != 0) begin
         rem = x % y;
         x   = y;
         y   = rem;
      end
      // x now holds the gcd, never zero as mag is not
      mag = mag / x;
      den = den / x;
      res.sum_num = SUM_NUM_W'((num < 0) ? -mag : mag);
      res.sum_den = SUM_DEN_W'(den);
      return res;
   endfunction

   // compare before queueing: a result can never belong to the item taken at the same edge
   always @(posedge clock) begin : watch
      sum_type want;
      sum_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.sum_num = rsp_tdata[SUM_NUM_LSB +: SUM_NUM_W];
            got.sum_den = rsp_tdata[SUM_DEN_LSB +: SUM_DEN_W];
            if (expected_sums.size() == 0) begin
               $error("unexpected result: sum_num %0d, sum_den %0d", got.sum_num, got.sum_den);
               fail_count++;
            end else begin
               want = expected_sums.pop_front();
               if (got.sum_num !== want.sum_num) begin
                  $error("sum_num: expected %0d, actual %0d", want.sum_num, got.sum_num);
                  fail_count++;
               end
               if (got.sum_den !== want.sum_den) begin
                  $error("sum_den: expected %0d, actual %0d", want.sum_den, got.sum_den);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_sums.push_back(reduced_sum(req_tdata));
         pending_sums = expected_sums.size();
      end
   end

endmodule

FILE: test/tb_rational_add_reduce_core.sv
module tb_rational_add_reduce_core;
   import rar_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 20000;
   // longer than the slowest item, so a stray result would still show up
   localparam int DRAIN_CYCLES = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // a_num, a_den, b_num, b_den, pad
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // sum_num, sum_den, pad

   int          fail_count;
   int          pending_sums;
   int unsigned idle_cycles = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   always #4 clock = ~clock;

   rational_add_reduce_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rational_sum_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .pending_sums (pending_sums)
   );

   // denominators: full range, small, powers of two, multiples of 2 to 12, near the top, rarely zero
   function automatic logic [DEN_W-1:0] pick_den();
      int unsigned f;
      if ($urandom_range(199, 0) == 0)
         return '0;
      case ($urandom_range(4, 0))
         0: return DEN_W'($urandom_range(32767, 1));
         1: return DEN_W'($urandom_range(16, 1));
         2: return DEN_W'(1 << $urandom_range(14, 0));
         3: begin
            f = $urandom_range(12, 2);
            return DEN_W'(f * $urandom_range(32767 / f, 1));
         end
         default: return DEN_W'($urandom_range(32767, 32700));
      endcase
   endfunction

   // numerators: full range, small of either sign, extremes, multiples of 12
   function automatic logic [NUM_W-1:0] pick_num();
      int f;
      case ($urandom_range(4, 0))
         0, 1: return NUM_W'($urandom);
         2: return NUM_W'($urandom_range(16, 0) - 8);
         3: begin
            case ($urandom_range(3, 0))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return '1;
               default: return '0;
            endcase
         end
         default: begin
            f = 12 * $urandom_range(2730, 0);
            return NUM_W'(($urandom_range(1, 0) != 0) ? -f : f);
         end
      endcase
   endfunction

   // one item on the request channel after a random gap; returns at the accepting edge
   task automatic send_fractions(input logic [NUM_W-1:0] a_num, input logic [DEN_W-1:0] a_den,
                                 input logic [NUM_W-1:0] b_num, input logic [DEN_W-1:0] b_den);
      int unsigned gap;
      if ($urandom_range(29, 0) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(18, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_USED_W){1'b0}}, b_den, b_num, a_den, a_num};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending until every outstanding sum has come back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sums != 0) @(posedge clock);
   endtask

   // result side: random stall before each item, with calm stretches
   initial begin : rsp_side
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(29, 0) == 0)
            rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(18, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** rational_add_reduce_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [NUM_W-1:0] an;
      logic [NUM_W-1:0] bn;
      logic [DEN_W-1:0] ad;
      logic [DEN_W-1:0] bd;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, cancelling sums, reduction, zero denominators
      send_fractions(16'd0, 15'd1, 16'd0, 15'd1);
      send_fractions(16'd1, 15'd2, 16'd1, 15'd2);
      send_fractions(16'h8000, 15'd1, 16'h8000, 15'd1);
      send_fractions(16'h7fff, 15'd1, 16'h7fff, 15'd1);
      send_fractions(16'h8000, 15'd32767, 16'h8000, 15'd32767);
      send_fractions(16'h7fff, 15'd32767, 16'h7fff, 15'd32767);
      send_fractions(16'h8000, 15'd32767, 16'h7fff, 15'd32766);
      send_fractions(16'd1, 15'd32767, 16'd1, 15'd32766);
      send_fractions(16'd1, 15'd32767, -16'sd1, 15'd32767);
      send_fractions(16'd5, 15'd3, -16'sd5, 15'd3);
      send_fractions(16'd3, 15'd4, -16'sd1, 15'd4);
      send_fractions(16'd1, 15'd3, 16'd1, 15'd6);
      send_fractions(-16'sd7, 15'd12, 16'd1, 15'd18);
      send_fractions(16'd1, 15'd32767, 16'd1, 15'd32767);
      send_fractions(16'h7fff, 15'd16384, 16'd1, 15'd16384);
      send_fractions(-16'sd1, 15'd1, 16'd0, 15'd7);
      send_fractions(16'h5555, 15'h2aaa, 16'haaaa, 15'h5555);
      send_fractions(16'h8000, 15'd16384, 16'h8000, 15'd8192);
      send_fractions(16'd3, 15'd0, 16'd2, 15'd5);
      send_fractions(-16'sd3, 15'd0, 16'd2, 15'd5);
      send_fractions(16'd4, 15'd0, 16'd4, 15'd0);
      send_fractions(16'd1, 15'd2, 16'd0, 15'd0);
      hold_until_drained();

      // random: cancelling pairs, shared denominators, related denominators, free mix
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         an = pick_num();
         ad = pick_den();
         bn = pick_num();
         bd = pick_den();
         case ($urandom_range(9, 0))
            0: begin
               bn = -an;
               bd = ad;
            end
            1: bd = ad;
            2: if (ad <= 1365) bd = DEN_W'(ad * $urandom_range(24, 1));
            default: ;
         endcase
         send_fractions(an, ad, bn, bd);
         if (n % 275 == 274)
            hold_until_drained();
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_sums == 0)
         $display("** rational_add_reduce_core: PASSED **");
      else
         $display("** rational_add_reduce_core: FAILED **");
      $finish;
   end

endmodule

FILE: rational_add_reduce_core.f
+incdir+rtl/core
rtl/core/rar_pkg.sv
rtl/core/rational_add_reduce_core.sv
rtl/core/rar_checker.sv
test/rational_sum_checker.sv
test/tb_rational_add_reduce_core.sv
